>>> hw/rtl/pbca_pkg.sv
// Shared constants and types for the pixel brightness and contrast adjuster.
package pbca_pkg;

   localparam int LANES            = 4;
   localparam int PIX_W            = 8;
   localparam int PIX_MAX          = 255;
   localparam int PIX_MID          = 128;
   localparam int FACTOR_FRAC_BITS = 16;
   localparam int FACTOR_W         = 8 + FACTOR_FRAC_BITS;
   localparam int OFFSET_W         = 9;
   localparam int LEVEL_W          = 9;
   localparam int SUM_W            = OFFSET_W + 1;
   localparam int DIFF_W           = PIX_W + 1;
   localparam int PROD_W           = FACTOR_W + 1 + DIFF_W;
   localparam int PASS_LANE        = 3;
   localparam int CSR_IDX_W        = 2;
   localparam int CSR_DATA_W       = 9;

   localparam logic [FACTOR_W-1:0] FACTOR_ONE =
      {{(FACTOR_W - FACTOR_FRAC_BITS - 1){1'b0}}, 1'b1, {FACTOR_FRAC_BITS{1'b0}}};

   localparam logic FMT_GRAY  = 1'b0;
   localparam logic FMT_COLOR = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BRIGHTNESS = 2'd0,
      CSR_CONTRAST   = 2'd1,
      CSR_FORMAT     = 2'd2
   } csr_index_type;

   typedef logic [PIX_W-1:0] pixel_type;
   typedef pixel_type [LANES-1:0] lane_vec_type;

endpackage

>>> hw/rtl/pbca_factor_div.sv
// Contrast factor computation: a restoring divider that runs one quotient bit per cycle.
module pbca_factor_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [pbca_pkg::LEVEL_W-1:0]  level,
   output logic                                 busy,
   output logic [pbca_pkg::FACTOR_W-1:0]        factor
);
   import pbca_pkg::*;

   localparam int NUM_W = 18;
   localparam int DEN_W = 17;
   localparam int DVD_W = NUM_W + FACTOR_FRAC_BITS + 1;
   localparam int CNT_W = $clog2(DVD_W + 1);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type            state_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [DVD_W-1:0]     dvd_ff;
   logic [DEN_W-1:0]     rem_ff;
   logic [DEN_W-1:0]     den_ff;
   logic                 zero_ff;
   logic [FACTOR_W-1:0]  factor_ff;

   logic signed [SUM_W-1:0] level_sum;
   logic                    level_nonpos;
   logic [NUM_W-1:0]        num;
   logic [SUM_W-1:0]        den_base;
   logic [DEN_W-1:0]        den;
   logic [DVD_W-1:0]        dividend;
   logic [DEN_W:0]          trial;
   logic                    fits;
   logic [DEN_W-1:0]        rem_in;
   logic [DVD_W-1:0]        dvd_in;
   logic [FACTOR_W-1:0]     quot_sat;

   // Numerator 259*(C+255) and denominator 255*(259-C); a non-positive numerator gives zero.
   always_comb begin
      level_sum    = $signed({level[LEVEL_W-1], level}) + SUM_W'(255);
      level_nonpos = level_sum[SUM_W-1] || (level_sum == '0);
      num          = NUM_W'(level_sum[SUM_W-2:0]) * NUM_W'(259);
      den_base     = SUM_W'(259) - {level[LEVEL_W-1], level};
      den          = DEN_W'(den_base) * DEN_W'(255);
      dividend     = DVD_W'({num, {FACTOR_FRAC_BITS{1'b0}}}) + DVD_W'(den >> 1);
   end

   always_comb begin
      trial  = {rem_ff, dvd_ff[DVD_W-1]};
      fits   = trial >= {1'b0, den_ff};
      rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
      dvd_in = {dvd_ff[DVD_W-2:0], fits};
      if (|dvd_in[DVD_W-1:FACTOR_W]) begin
         quot_sat = '1;
      end else begin
         quot_sat = dvd_in[FACTOR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         factor_ff <= FACTOR_ONE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_RUN;
                  cnt_ff   <= '0;
                  dvd_ff   <= dividend;
                  rem_ff   <= '0;
                  den_ff   <= den;
                  zero_ff  <= level_nonpos;
               end
            end
            ST_RUN: begin
               dvd_ff <= dvd_in;
               rem_ff <= rem_in;
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(DVD_W - 1)) begin
                  state_ff  <= ST_IDLE;
                  factor_ff <= zero_ff ? '0 : quot_sat;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy   = (state_ff == ST_RUN);
   assign factor = factor_ff;

endmodule

>>> hw/rtl/pbca_pipe.sv
// Three-stage lane datapath: brightness clamp, contrast multiply, add 128, clamp.
module pbca_pipe (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_stall,
   input  pbca_pkg::lane_vec_type               in_lanes,
   input  logic                                 in_last,
   input  logic                                 hold,
   input  logic signed [pbca_pkg::OFFSET_W-1:0] offset,
   input  logic [pbca_pkg::FACTOR_W-1:0]        factor,
   input  logic                                 color,
   output logic                                 out_valid,
   input  logic                                 out_stall,
   output pbca_pkg::lane_vec_type               out_lanes,
   output logic                                 out_last
);
   import pbca_pkg::*;

   localparam int WHOLE_W = PROD_W - 1 - FACTOR_FRAC_BITS;
   localparam logic signed [PROD_W-1:0] MID_FIX =
      PROD_W'(longint'(PIX_MID) << FACTOR_FRAC_BITS);

   logic                     v1_ff, v2_ff, v3_ff;
   logic                     last1_ff, last2_ff, last3_ff;
   lane_vec_type             raw1_ff, raw2_ff;
   lane_vec_type             bright1_ff;
   logic signed [PROD_W-1:0] prod2_ff [LANES];
   lane_vec_type             out3_ff;

   logic                     en1, en2, en3, accept;
   logic signed [SUM_W-1:0]  sum    [LANES];
   lane_vec_type             bright_in;
   logic signed [DIFF_W-1:0] diff   [LANES];
   logic signed [PROD_W-1:0] prod_in [LANES];
   logic signed [PROD_W-1:0] scaled [LANES];
   logic [WHOLE_W-1:0]       whole  [LANES];
   lane_vec_type             out_in;

   // A stage loads when it is empty or when the stage after it moves.
   assign en3      = !v3_ff || !out_stall;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_stall = hold || !en1;
   assign accept   = in_valid && !in_stall;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         sum[i] = $signed({2'b00, in_lanes[i]}) + $signed({offset[OFFSET_W-1], offset});
         if (sum[i][SUM_W-1]) begin
            bright_in[i] = '0;
         end else if (sum[i][SUM_W-2]) begin
            bright_in[i] = PIX_W'(PIX_MAX);
         end else begin
            bright_in[i] = sum[i][PIX_W-1:0];
         end

         diff[i]    = $signed({1'b0, bright1_ff[i]}) - $signed(DIFF_W'(PIX_MID));
         prod_in[i] = $signed({1'b0, factor}) * diff[i];

         // Negative sums clamp to zero, so truncation and flooring agree.
         scaled[i] = prod2_ff[i] + MID_FIX;
         whole[i]  = scaled[i][PROD_W-2:FACTOR_FRAC_BITS];
         if (color == FMT_COLOR && i >= PASS_LANE) begin
            out_in[i] = raw2_ff[i];
         end else if (scaled[i][PROD_W-1]) begin
            out_in[i] = '0;
         end else if (|whole[i][WHOLE_W-1:PIX_W]) begin
            out_in[i] = PIX_W'(PIX_MAX);
         end else begin
            out_in[i] = whole[i][PIX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= accept;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         bright1_ff <= bright_in;
         raw1_ff    <= in_lanes;
         last1_ff   <= in_last;
      end
      if (en2) begin
         for (int i = 0; i < LANES; i++) begin
            prod2_ff[i] <= prod_in[i];
         end
         raw2_ff  <= raw1_ff;
         last2_ff <= last1_ff;
      end
      if (en3) begin
         out3_ff  <= out_in;
         last3_ff <= last2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_lanes = out3_ff;
   assign out_last  = last3_ff;

endmodule

>>> hw/rtl/pixel_brightness_contrast_adjust.sv
// Pixel brightness and contrast adjuster: takes one request of four 8-bit lanes per clock
// while req_stall is low and passes it through a three-stage pipeline (brightness add and
// clamp, contrast multiply, offset and clamp) that stalls stage by stage.
// A write to the contrast register starts a bit-serial divider that computes the contrast
// factor; while it runs csr_ready is low and req_stall is high.
// Registers should be written only while the pipeline is empty.
module pixel_brightness_contrast_adjust (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [pbca_pkg::PIX_W-1:0]          req_lane0_in,
   input  logic [pbca_pkg::PIX_W-1:0]          req_lane1_in,
   input  logic [pbca_pkg::PIX_W-1:0]          req_lane2_in,
   input  logic [pbca_pkg::PIX_W-1:0]          req_lane3_in,
   input  logic                                req_last_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pbca_pkg::PIX_W-1:0]          rsp_lane0_out,
   output logic [pbca_pkg::PIX_W-1:0]          rsp_lane1_out,
   output logic [pbca_pkg::PIX_W-1:0]          rsp_lane2_out,
   output logic [pbca_pkg::PIX_W-1:0]          rsp_lane3_out,
   output logic                                rsp_last_out,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pbca_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pbca_pkg::CSR_DATA_W-1:0]     csr_data
);
   import pbca_pkg::*;

   logic signed [OFFSET_W-1:0] offset_ff;
   logic                       format_ff;
   logic                       csr_write;
   logic                       div_start;
   logic                       div_busy;
   logic [FACTOR_W-1:0]        factor;
   lane_vec_type               in_lanes;
   lane_vec_type               out_lanes;

   assign csr_ready = !div_busy;
   assign csr_write = csr_valid && csr_ready;
   assign div_start = csr_write && (csr_index_type'(csr_index) == CSR_CONTRAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         format_ff <= FMT_GRAY;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_BRIGHTNESS: offset_ff <= $signed(csr_data[OFFSET_W-1:0]);
            CSR_FORMAT:     format_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   pbca_factor_div u_factor_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .level  ($signed(csr_data[LEVEL_W-1:0])),
      .busy   (div_busy),
      .factor (factor)
   );

   assign in_lanes[0] = req_lane0_in;
   assign in_lanes[1] = req_lane1_in;
   assign in_lanes[2] = req_lane2_in;
   assign in_lanes[3] = req_lane3_in;

   pbca_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_lanes  (in_lanes),
      .in_last   (req_last_in),
      .hold      (div_busy),
      .offset    (offset_ff),
      .factor    (factor),
      .color     (format_ff),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_lanes (out_lanes),
      .out_last  (rsp_last_out)
   );

   assign rsp_lane0_out = out_lanes[0];
   assign rsp_lane1_out = out_lanes[1];
   assign rsp_lane2_out = out_lanes[2];
   assign rsp_lane3_out = out_lanes[3];

`ifndef NO_ASSERTIONS
   // No request may enter while the contrast factor is being recomputed.
   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !div_busy)
      else $error("request accepted while contrast factor is being computed");

   // A contrast write always starts the divider.
   a_contrast_starts_div: assert property (@(posedge clock) disable iff (reset)
      div_start |=> div_busy)
      else $error("contrast write did not start the factor divider");

   // The factor changes only when a division finishes.
   a_factor_stable: assert property (@(posedge clock) disable iff (reset)
      (!reset && $past(!reset) && !div_busy && !$past(div_busy)) |-> $stable(factor))
      else $error("contrast factor changed outside a division");
`endif

endmodule
